// ===== rtl/core/lpcbp_pkg.sv =====
// Shared types, constants and helpers for the lidar point camera box painter.
// Depends on nothing; every other file in rtl/core imports it.
package lpcbp_pkg;

    localparam int MAX_BOXES_DEF = 32;
    localparam int COEF_SLOTS    = 12;
    // Projected rows stay below 2^48 in magnitude, so 50 signed bits hold them.
    localparam int ROW_W         = 50;
    localparam int MAG_W         = ROW_W - 1;

    typedef enum logic [1:0] {
        CMD_LOAD_COEF   = 2'd0,
        CMD_APPEND_BOX  = 2'd1,
        CMD_CLEAR_BOXES = 2'd2,
        CMD_PAINT       = 2'd3
    } cmd_t;

    localparam logic [2:0] CLS_UNKNOWN    = 3'd0;
    localparam logic [2:0] CLS_CAR        = 3'd1;
    localparam logic [2:0] CLS_TRUCK      = 3'd2;
    localparam logic [2:0] CLS_BUS        = 3'd3;
    localparam logic [2:0] CLS_TRAILER    = 3'd4;
    localparam logic [2:0] CLS_MOTORCYCLE = 3'd5;
    localparam logic [2:0] CLS_BICYCLE    = 3'd6;
    localparam logic [2:0] CLS_PEDESTRIAN = 3'd7;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] width;
        logic [15:0] height;
        logic [2:0]  cls;
    } box_t;

    // Control that travels with every item down the pipeline.
    typedef struct packed {
        cmd_t cmd;
        logic ok;     // point passed depth, field-of-view and denominator tests
        box_t box;
    } tag_t;

    function automatic logic is_vehicle(input logic [2:0] cls);
        logic r;
        case (cls)
            CLS_CAR, CLS_TRUCK, CLS_BUS, CLS_TRAILER: r = 1'b1;
            default:                                  r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_cycle(input logic [2:0] cls);
        logic r;
        case (cls)
            CLS_MOTORCYCLE, CLS_BICYCLE: r = 1'b1;
            default:                     r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/lpcbp_project.sv =====
// Projection front end: matrix storage, the nine row products, row sums,
// the view test and the denominator test. Depends on lpcbp_pkg.
module lpcbp_project import lpcbp_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_vld,
    input  cmd_t                    in_cmd,
    input  box_t                    in_box,
    input  logic [3:0]              coef_slot,
    input  logic signed [31:0]      coef_value,
    input  logic signed [31:0]      px,
    input  logic signed [31:0]      py,
    input  logic signed [31:0]      pz,
    input  logic [31:0]             fov,
    output logic                    out_vld,
    output tag_t                    out_tag,
    output logic                    out_neg_u,
    output logic                    out_neg_v,
    output logic [MAG_W-1:0]        out_num_u,
    output logic [MAG_W-1:0]        out_num_v,
    output logic [MAG_W-1:0]        out_den
);

    logic [31:0]               mat_reg [COEF_SLOTS];
    logic signed [31:0]        coord [3];
    logic [31:0]               ax;

    logic                      s1_vld_reg;
    tag_t                      s1_tag_reg;
    logic signed [63:0]        prod_reg [9];
    logic signed [31:0]        off_reg [3];
    logic [62:0]               fovz_reg;
    logic [47:0]               axs_reg;
    logic                      zpos_reg;

    logic                      s2_vld_reg;
    tag_t                      s2_tag_reg;
    logic signed [ROW_W-1:0]   row_reg [3];
    logic                      view_reg;

    logic                      den_ok;
    tag_t                      tag_next;

    assign coord[0] = px;
    assign coord[1] = py;
    assign coord[2] = pz;
    assign ax = px[31] ? 32'(-px) : px;

    always_ff @(posedge aclk) begin
        if (en && in_vld && in_cmd == CMD_LOAD_COEF && coef_slot < 4'(COEF_SLOTS)) begin
            mat_reg[coef_slot] <= coef_value;
        end
    end

    // Stage 1: products against the current matrix.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_tag_reg.cmd <= in_cmd;
            s1_tag_reg.ok  <= 1'b0;
            s1_tag_reg.box <= in_box;
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    prod_reg[r*3+k] <= 64'($signed(mat_reg[r*4+k])) * 64'(coord[k]);
                end
                off_reg[r] <= $signed(mat_reg[r*4+3]);
            end
            fovz_reg <= 63'(fov) * 63'(pz[30:0]);
            axs_reg  <= {ax, 16'b0};
            zpos_reg <= !pz[31] && (pz != 32'sd0);
        end
    end

    // Stage 2: floor each product to Q16.16 and sum the rows.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_tag_reg <= s1_tag_reg;
            for (int r = 0; r < 3; r++) begin
                row_reg[r] <= ROW_W'(prod_reg[r*3]   >>> 16)
                            + ROW_W'(prod_reg[r*3+1] >>> 16)
                            + ROW_W'(prod_reg[r*3+2] >>> 16)
                            + ROW_W'(off_reg[r]);
            end
            view_reg <= zpos_reg && ({15'b0, axs_reg} <= fovz_reg);
        end
    end

    // Stage 3: denominator test and magnitudes for the dividers.
    assign den_ok = !row_reg[2][ROW_W-1] && (row_reg[2] != '0);

    always_comb begin
        tag_next    = s2_tag_reg;
        tag_next.ok = view_reg && den_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld <= 1'b0;
        end else if (en) begin
            out_vld <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_tag   <= tag_next;
            out_neg_u <= row_reg[0][ROW_W-1];
            out_neg_v <= row_reg[1][ROW_W-1];
            out_num_u <= row_reg[0][ROW_W-1] ? MAG_W'(-row_reg[0]) : row_reg[0][MAG_W-1:0];
            out_num_v <= row_reg[1][ROW_W-1] ? MAG_W'(-row_reg[1]) : row_reg[1][MAG_W-1:0];
            out_den   <= row_reg[2][MAG_W-1:0];
        end
    end

endmodule

// ===== rtl/core/lpcbp_divide.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage,
// with a passenger word that rides alongside. Depends on lpcbp_pkg.
module lpcbp_divide import lpcbp_pkg::*; #(
    parameter int W  = MAG_W,
    parameter int PW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_vld,
    input  logic [PW-1:0] in_pass,
    input  logic [W-1:0]  in_num,
    input  logic [W-1:0]  in_den,
    output logic          out_vld,
    output logic [PW-1:0] out_pass,
    output logic [W-1:0]  out_quo,
    output logic [W-1:0]  out_rem
);

    logic          vld_reg  [W];
    logic [PW-1:0] pass_reg [W];
    logic [W-1:0]  rem_reg  [W];
    logic [W-1:0]  nq_reg   [W];
    logic [W-1:0]  den_reg  [W];

    logic          vld_d  [W];
    logic [PW-1:0] pass_d [W];
    logic [W-1:0]  rem_d  [W];
    logic [W-1:0]  nq_d   [W];
    logic [W-1:0]  den_d  [W];

    assign vld_d[0]  = in_vld;
    assign pass_d[0] = in_pass;
    assign rem_d[0]  = '0;
    assign nq_d[0]   = in_num;
    assign den_d[0]  = in_den;

    for (genvar i = 0; i < W; i++) begin : g_stage
        logic [W:0] trial;
        logic       ge;

        if (i > 0) begin : g_link
            assign vld_d[i]  = vld_reg[i-1];
            assign pass_d[i] = pass_reg[i-1];
            assign rem_d[i]  = rem_reg[i-1];
            assign nq_d[i]   = nq_reg[i-1];
            assign den_d[i]  = den_reg[i-1];
        end

        // The remainder shifts in the next numerator bit; the freed low bit
        // of the shifting word takes the quotient bit.
        assign trial = {rem_d[i], nq_d[i][W-1]};
        assign ge    = trial >= {1'b0, den_d[i]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_d[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                pass_reg[i] <= pass_d[i];
                den_reg[i]  <= den_d[i];
                rem_reg[i]  <= ge ? W'(trial - {1'b0, den_d[i]}) : trial[W-1:0];
                nq_reg[i]   <= {nq_d[i][W-2:0], ge};
            end
        end
    end

    assign out_vld  = vld_reg[W-1];
    assign out_pass = pass_reg[W-1];
    assign out_quo  = nq_reg[W-1];
    assign out_rem  = rem_reg[W-1];

endmodule

// ===== rtl/core/lpcbp_boxes.sv =====
// Floor correction of the quotients, the box list and the parallel box
// compare with per-class hit vectors. Depends on lpcbp_pkg.
module lpcbp_boxes import lpcbp_pkg::*; #(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_vld,
    input  tag_t               in_tag,
    input  logic               neg_u,
    input  logic               neg_v,
    input  logic [MAG_W-1:0]   quo_u,
    input  logic [MAG_W-1:0]   quo_v,
    input  logic               rnz_u,
    input  logic               rnz_v,
    output logic               out_vld,
    output tag_t               out_tag,
    output logic [15:0]        out_pixel_u,
    output logic [15:0]        out_pixel_v,
    output logic               out_vehicle,
    output logic               out_pedestrian,
    output logic               out_cycle
);

    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

    function automatic logic signed [ROW_W-1:0] floor_quo(
        input logic neg, input logic [MAG_W-1:0] qm, input logic rnz);
        logic signed [ROW_W-1:0] q;
        q = $signed({1'b0, qm});
        if (neg) begin
            q = -q - (rnz ? ROW_W'(1) : ROW_W'(0));
        end
        return q;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [ROW_W-1:0] q);
        logic [15:0] r;
        if (q > ROW_W'(32767)) begin
            r = 16'h7FFF;
        end else if (q < -ROW_W'(32768)) begin
            r = 16'h8000;
        end else begin
            r = q[15:0];
        end
        return r;
    endfunction

    // Inclusive span check on the exact quotient: a nonzero remainder puts the
    // true value just above q, so the upper edge then needs q strictly below.
    function automatic logic span_hit(input logic signed [ROW_W-1:0] q, input logic rz,
                                      input logic [15:0] lo, input logic [15:0] ext);
        logic signed [ROW_W-1:0] l;
        logic signed [ROW_W-1:0] h;
        l = $signed(ROW_W'(lo));
        h = $signed(ROW_W'({1'b0, lo} + {1'b0, ext}));
        return (q >= l) && ((q < h) || (q == h && rz));
    endfunction

    logic                      f_vld_reg;
    tag_t                      f_tag_reg;
    logic signed [ROW_W-1:0]   qu_reg;
    logic signed [ROW_W-1:0]   qv_reg;
    logic                      rzu_reg;
    logic                      rzv_reg;

    logic [15:0]               left_reg   [MAX_BOXES];
    logic [15:0]               top_reg    [MAX_BOXES];
    logic [15:0]               width_reg  [MAX_BOXES];
    logic [15:0]               height_reg [MAX_BOXES];
    logic [2:0]                cls_reg    [MAX_BOXES];
    logic [CNT_W-1:0]          count_reg;

    logic [MAX_BOXES-1:0]      veh_reg;
    logic [MAX_BOXES-1:0]      ped_reg;
    logic [MAX_BOXES-1:0]      cyc_reg;
    logic                      b_vld_reg;
    tag_t                      b_tag_reg;
    logic [15:0]               pu_reg;
    logic [15:0]               pv_reg;

    logic                      append;

    // Stage F: signed floor quotients.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_vld_reg <= 1'b0;
        end else if (en) begin
            f_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_tag_reg <= in_tag;
            qu_reg    <= floor_quo(neg_u, quo_u, rnz_u);
            qv_reg    <= floor_quo(neg_v, quo_v, rnz_v);
            rzu_reg   <= !rnz_u;
            rzv_reg   <= !rnz_v;
        end
    end

    // Stage B: box list updates land here, in order with the compares.
    assign append = en && f_vld_reg && f_tag_reg.cmd == CMD_APPEND_BOX
                 && count_reg < CNT_W'(MAX_BOXES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (en && f_vld_reg && f_tag_reg.cmd == CMD_CLEAR_BOXES) begin
            count_reg <= '0;
        end else if (append) begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (append) begin
            left_reg[count_reg[IDX_W-1:0]]   <= f_tag_reg.box.left;
            top_reg[count_reg[IDX_W-1:0]]    <= f_tag_reg.box.top;
            width_reg[count_reg[IDX_W-1:0]]  <= f_tag_reg.box.width;
            height_reg[count_reg[IDX_W-1:0]] <= f_tag_reg.box.height;
            cls_reg[count_reg[IDX_W-1:0]]    <= f_tag_reg.box.cls;
        end
    end

    for (genvar i = 0; i < MAX_BOXES; i++) begin : g_box
        logic hit;
        assign hit = (CNT_W'(i) < count_reg) && (cls_reg[i] != CLS_UNKNOWN)
                  && span_hit(qu_reg, rzu_reg, left_reg[i], width_reg[i])
                  && span_hit(qv_reg, rzv_reg, top_reg[i], height_reg[i]);

        always_ff @(posedge aclk) begin
            if (en) begin
                veh_reg[i] <= hit && is_vehicle(cls_reg[i]);
                cyc_reg[i] <= hit && is_cycle(cls_reg[i]);
                ped_reg[i] <= hit && (cls_reg[i] == CLS_PEDESTRIAN);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (en) begin
            b_vld_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_tag_reg <= f_tag_reg;
            pu_reg    <= sat16(qu_reg);
            pv_reg    <= sat16(qv_reg);
        end
    end

    assign out_vld        = b_vld_reg;
    assign out_tag        = b_tag_reg;
    assign out_pixel_u    = pu_reg;
    assign out_pixel_v    = pv_reg;
    assign out_vehicle    = |veh_reg;
    assign out_pedestrian = |ped_reg;
    assign out_cycle      = |cyc_reg;

endmodule

// ===== rtl/core/lidar_point_camera_box_painter.sv =====
// A paint command's result reaches m_valid after its input transfer passes through
// 3 projection stages, 49 divider stages, 2 box stages and 1 output register; the
// first stage loads on the transfer edge itself.
// Throughput: one command per cycle unless the output stalls; the one-bit-per-stage dividers set the depth.
// A held result that waits on m_ready freezes the whole pipeline.
// Reset (aresetn, synchronous, active low) empties the pipeline, clears the box
// count and sets fov_tangent to 1.0; matrix and box entries hold until written.
// Depends on lpcbp_pkg, lpcbp_project, lpcbp_divide and lpcbp_boxes.
module lidar_point_camera_box_painter import lpcbp_pkg::*; #(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [3:0]         s_coefficient_slot,
    input  logic signed [31:0] s_coefficient_value,
    input  logic signed [31:0] s_point_x,
    input  logic signed [31:0] s_point_y,
    input  logic signed [31:0] s_point_z,
    input  logic [15:0]        s_box_left,
    input  logic [15:0]        s_box_top,
    input  logic [15:0]        s_box_width,
    input  logic [15:0]        s_box_height,
    input  logic [2:0]         s_box_class,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_in_view,
    output logic signed [15:0] m_pixel_u,
    output logic signed [15:0] m_pixel_v,
    output logic               m_vehicle_mark,
    output logic               m_pedestrian_mark,
    output logic               m_cycle_mark
);

    // The whole pipeline moves as one: it advances whenever the output
    // register is empty or its result is being taken in this cycle. Every
    // command travels the full depth so that matrix loads and box list
    // updates take effect in order with the points around them.
    logic        en;
    logic [31:0] fov_reg;
    box_t        in_box;

    logic              p_vld;
    tag_t              p_tag;
    logic              p_neg_u;
    logic              p_neg_v;
    logic [MAG_W-1:0]  p_num_u;
    logic [MAG_W-1:0]  p_num_v;
    logic [MAG_W-1:0]  p_den;

    logic                 du_vld;
    logic [$bits(tag_t):0] du_pass;
    logic [MAG_W-1:0]     du_quo;
    logic [MAG_W-1:0]     du_rem;
    logic                 dv_vld;
    logic                 dv_neg;
    logic [MAG_W-1:0]     dv_quo;
    logic [MAG_W-1:0]     dv_rem;
    tag_t                 d_tag;

    logic        b_vld;
    tag_t        b_tag;
    logic [15:0] b_pixel_u;
    logic [15:0] b_pixel_v;
    logic        b_vehicle;
    logic        b_pedestrian;
    logic        b_cycle;

    logic        m_valid_reg;
    logic        in_view_reg;
    logic [15:0] pixel_u_reg;
    logic [15:0] pixel_v_reg;
    logic        vehicle_reg;
    logic        pedestrian_reg;
    logic        cycle_reg;

    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    // Field-of-view tangent register; a configuration transfer replaces it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fov_reg <= 32'h0001_0000;
        end else if (cfg_valid && cfg_ready) begin
            fov_reg <= cfg_data;
        end
    end

    assign in_box.left   = s_box_left;
    assign in_box.top    = s_box_top;
    assign in_box.width  = s_box_width;
    assign in_box.height = s_box_height;
    assign in_box.cls    = s_box_class;

    lpcbp_project u_project (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_vld     (s_valid),
        .in_cmd     (cmd_t'(s_command)),
        .in_box     (in_box),
        .coef_slot  (s_coefficient_slot),
        .coef_value (s_coefficient_value),
        .px         (s_point_x),
        .py         (s_point_y),
        .pz         (s_point_z),
        .fov        (fov_reg),
        .out_vld    (p_vld),
        .out_tag    (p_tag),
        .out_neg_u  (p_neg_u),
        .out_neg_v  (p_neg_v),
        .out_num_u  (p_num_u),
        .out_num_v  (p_num_v),
        .out_den    (p_den)
    );

    // Both dividers share the denominator and step in lockstep; the column
    // divider carries the item's control alongside.
    lpcbp_divide #(
        .W  (MAG_W),
        .PW ($bits(tag_t) + 1)
    ) u_div_u (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (p_vld),
        .in_pass  ({p_tag, p_neg_u}),
        .in_num   (p_num_u),
        .in_den   (p_den),
        .out_vld  (du_vld),
        .out_pass (du_pass),
        .out_quo  (du_quo),
        .out_rem  (du_rem)
    );

    lpcbp_divide #(
        .W  (MAG_W),
        .PW (1)
    ) u_div_v (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (p_vld),
        .in_pass  (p_neg_v),
        .in_num   (p_num_v),
        .in_den   (p_den),
        .out_vld  (dv_vld),
        .out_pass (dv_neg),
        .out_quo  (dv_quo),
        .out_rem  (dv_rem)
    );

    assign d_tag = tag_t'(du_pass[$bits(tag_t):1]);

    lpcbp_boxes #(
        .MAX_BOXES (MAX_BOXES)
    ) u_boxes (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .in_vld         (du_vld && dv_vld),
        .in_tag         (d_tag),
        .neg_u          (du_pass[0]),
        .neg_v          (dv_neg),
        .quo_u          (du_quo),
        .quo_v          (dv_quo),
        .rnz_u          (du_rem != '0),
        .rnz_v          (dv_rem != '0),
        .out_vld        (b_vld),
        .out_tag        (b_tag),
        .out_pixel_u    (b_pixel_u),
        .out_pixel_v    (b_pixel_v),
        .out_vehicle    (b_vehicle),
        .out_pedestrian (b_pedestrian),
        .out_cycle      (b_cycle)
    );

    // Output register. Only paint commands produce a result; a point that
    // failed any view test reports all zeros.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= b_vld && b_tag.cmd == CMD_PAINT;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_view_reg    <= b_tag.ok;
            pixel_u_reg    <= b_tag.ok ? b_pixel_u : 16'h0000;
            pixel_v_reg    <= b_tag.ok ? b_pixel_v : 16'h0000;
            vehicle_reg    <= b_tag.ok && b_vehicle;
            pedestrian_reg <= b_tag.ok && b_pedestrian;
            cycle_reg      <= b_tag.ok && b_cycle;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_in_view         = in_view_reg;
    assign m_pixel_u         = $signed(pixel_u_reg);
    assign m_pixel_v         = $signed(pixel_v_reg);
    assign m_vehicle_mark    = vehicle_reg;
    assign m_pedestrian_mark = pedestrian_reg;
    assign m_cycle_mark      = cycle_reg;

endmodule
